// ----- src/sws_pkg.sv -----
// Shared types, codes and constants of the sliding window sender.
// Used by the channel interfaces and by every module of the block.
`timescale 1ns / 1ps

package sws_pkg;

    // Default sizing of the window store and the largest segment payload.
    localparam int DEF_WINDOW      = 16;
    localparam int DEF_MAX_SEGMENT = 1024;

    // Fixed field widths.
    localparam int SEQ_W     = 32;
    localparam int LEN_W     = 11;
    localparam int OUTST_W   = 5;
    localparam int LIMIT_W   = 5;
    localparam int THR_W     = 4;
    localparam int CFG_IDX_W = 4;
    localparam int CFG_DAT_W = 8;

    // Depth of the command queue between front and back (a power of two).
    localparam int QUEUE_DEPTH = 2;

    // Configuration register indexes and reset values.
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LIMIT  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_DUP_THRESHOLD = CFG_IDX_W'(1);
    localparam logic [LIMIT_W-1:0]   LIMIT_RESET       = LIMIT_W'(10);
    localparam logic [THR_W-1:0]     THR_RESET         = THR_W'(3);

    // Input opcodes.
    localparam logic OPC_OFFER = 1'b0;
    localparam logic OPC_ACK   = 1'b1;

    // Result kinds.
    typedef enum logic [1:0] {
        KIND_SEND   = 2'd0,
        KIND_RETX   = 2'd1,
        KIND_STATUS = 2'd2,
        KIND_REJECT = 2'd3
    } kind_t;

    // Commands that the front hands to the back.
    typedef enum logic [1:0] {
        CMD_OFFER   = 2'd0,
        CMD_STATUS  = 2'd1,
        CMD_RETX    = 2'd2,
        CMD_NEW_ACK = 2'd3
    } cmd_op_t;

    typedef struct packed {
        cmd_op_t              op;
        logic [SEQ_W-1:0]     value;
        logic [LEN_W-1:0]     len;
    } cmd_t;

    typedef struct packed {
        kind_t                kind;
        logic [SEQ_W-1:0]     seq_number;
        logic [LEN_W-1:0]     length;
        logic                 last;
        logic [OUTST_W-1:0]   outstanding;
        logic                 done_res;
    } result_t;

endpackage

// ----- src/sws_ifs.sv -----
// Channel interfaces of the sliding window sender: input items, results and
// configuration writes. Depends on sws_pkg for the field widths.
`timescale 1ns / 1ps

interface sws_in_if;
    import sws_pkg::*;

    logic             valid;
    logic             ready;
    logic             opcode;
    logic [LEN_W-1:0] segment_length;
    logic [SEQ_W-1:0] ack_number;

    modport source (output valid, opcode, segment_length, ack_number, input ready);
    modport sink   (input valid, opcode, segment_length, ack_number, output ready);
endinterface

interface sws_out_if;
    import sws_pkg::*;

    logic               valid;
    logic               ready;
    logic [1:0]         kind;
    logic [SEQ_W-1:0]   seq_number;
    logic [LEN_W-1:0]   length;
    logic               last;
    logic [OUTST_W-1:0] outstanding;
    logic               done_res;

    modport source (output valid, kind, seq_number, length, last, outstanding, done_res,
                    input ready);
    modport sink   (input valid, kind, seq_number, length, last, outstanding, done_res,
                    output ready);
endinterface

interface sws_cfg_if;
    import sws_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_DAT_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ----- src/sliding_window_sender.sv -----
// Top level of the sliding window sender: front end, command queue and back end.
// Depends on sws_pkg, the channel interfaces, sws_front, sws_queue and sws_back.
//
//   channel   direction   requests carried
//   item      in          offer or acknowledgement (opcode, segment_length, ack_number)
//   cfg       in          register write (index, data), always ready
//   result    out         kind, seq_number, length, last, outstanding, done_res
//
// An offer or a status request passes through the queue, dispatch and emit steps.
// A retransmit does one window read and one emit per window entry; each popped
// entry on a new acknowledgement passes a read step and a compare step, since the
// window store has a registered read port.
// Reset clears the control state only; the window store needs no clearing pass.
// A stalled result holds the back end, while the front keeps filling its queue.
`timescale 1ns / 1ps

module sliding_window_sender #(
    parameter int WINDOW      = sws_pkg::DEF_WINDOW,
    parameter int MAX_SEGMENT = sws_pkg::DEF_MAX_SEGMENT
) (
    input  logic      clk,
    input  logic      rst_n,
    sws_in_if.sink    item,
    sws_cfg_if.sink   cfg,
    sws_out_if.source result
);
    import sws_pkg::*;

    logic               push_valid, push_ready;
    cmd_t               push_cmd;
    logic               q_valid, q_pop;
    cmd_t               q_cmd;
    logic [LIMIT_W-1:0] window_limit;

    sws_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .cfg          (cfg),
        .push_valid   (push_valid),
        .push_ready   (push_ready),
        .push_cmd     (push_cmd),
        .window_limit (window_limit)
    );

    sws_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd),
        .pop_valid  (q_valid),
        .pop        (q_pop),
        .pop_cmd    (q_cmd)
    );

    sws_back #(
        .WINDOW      (WINDOW),
        .MAX_SEGMENT (MAX_SEGMENT)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_pop        (q_pop),
        .q_cmd        (q_cmd),
        .window_limit (window_limit),
        .result       (result)
    );

endmodule

// ----- src/sws_front.sv -----
// Front end: accepts input requests and configuration writes, keeps the
// acknowledgement history and classifies each request into a command.
`timescale 1ns / 1ps

module sws_front (
    input  logic                        clk,
    input  logic                        rst_n,
    sws_in_if.sink                      item,
    sws_cfg_if.sink                     cfg,
    output logic                        push_valid,
    input  logic                        push_ready,
    output sws_pkg::cmd_t               push_cmd,
    output logic [sws_pkg::LIMIT_W-1:0] window_limit
);
    import sws_pkg::*;

    logic [LIMIT_W-1:0] limit_reg;
    logic [THR_W-1:0]   thr_reg;
    logic [SEQ_W-1:0]   last_ack_reg, last_ack_next;
    logic [THR_W-1:0]   dup_count_reg, dup_count_next;
    logic [THR_W-1:0]   dup_inc;
    logic [THR_W-1:0]   thr_eff;
    logic               accept;

    assign cfg.ready    = 1'b1;
    assign item.ready   = push_ready;
    assign push_valid   = item.valid;
    assign accept       = item.valid && push_ready;
    assign window_limit = limit_reg;

    // Configuration registers; writes to unknown indexes are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= LIMIT_RESET;
            thr_reg   <= THR_RESET;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_WINDOW_LIMIT:  limit_reg <= cfg.data[LIMIT_W-1:0];
                REG_DUP_THRESHOLD: thr_reg   <= cfg.data[THR_W-1:0];
                default:           ;
            endcase
        end
    end

    // Classify the request and update the duplicate counter.
    always_comb
    begin
        dup_inc        = dup_count_reg + THR_W'(1);
        thr_eff        = (thr_reg == '0) ? THR_W'(1) : thr_reg;
        last_ack_next  = last_ack_reg;
        dup_count_next = dup_count_reg;
        push_cmd.op    = CMD_OFFER;
        push_cmd.value = last_ack_reg;
        push_cmd.len   = item.segment_length;

        if (item.opcode == OPC_ACK)
        begin
            if (item.ack_number <= last_ack_reg)
            begin
                // A duplicate either reports status or fires a retransmit.
                if (dup_inc >= thr_eff)
                begin
                    dup_count_next = '0;
                    push_cmd.op    = CMD_RETX;
                end
                else
                begin
                    dup_count_next = dup_inc;
                    push_cmd.op    = CMD_STATUS;
                end
            end
            else
            begin
                last_ack_next  = item.ack_number;
                dup_count_next = '0;
                push_cmd.op    = CMD_NEW_ACK;
                push_cmd.value = item.ack_number;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_ack_reg  <= '0;
            dup_count_reg <= '0;
        end
        else if (accept)
        begin
            last_ack_reg  <= last_ack_next;
            dup_count_reg <= dup_count_next;
        end
    end

endmodule

// ----- src/sws_queue.sv -----
// Short command queue that decouples the front end from the back end.
// Depends on sws_pkg for the command type and the queue depth.
`timescale 1ns / 1ps

module sws_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push_valid,
    output logic          push_ready,
    input  sws_pkg::cmd_t push_cmd,
    output logic          pop_valid,
    input  logic          pop,
    output sws_pkg::cmd_t pop_cmd
);
    import sws_pkg::*;

    localparam int QP_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QC_W = $clog2(QUEUE_DEPTH + 1);

    cmd_t              entry_reg [QUEUE_DEPTH];
    logic [QP_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [QC_W-1:0]   fill_reg, fill_next;
    logic              do_push, do_pop;

    assign push_ready = (fill_reg != QC_W'(QUEUE_DEPTH));
    assign pop_valid  = (fill_reg != '0);
    assign pop_cmd    = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;

    // Fill level follows pushes and pops.
    always_comb
    begin
        fill_next = fill_reg;
        if (do_push && !do_pop)
        begin
            fill_next = fill_reg + QC_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            fill_next = fill_reg - QC_W'(1);
        end
    end

    // Pointers wrap naturally since the depth is a power of two.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            fill_reg <= fill_next;
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QP_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QP_W'(1);
            end
        end
    end

    // Queue storage holds payload only.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ----- src/sws_back.sv -----
// Back end: owns the segment window and carries out the queued commands,
// sending, retransmitting and popping entries. Depends on sws_pkg.
`timescale 1ns / 1ps

module sws_back #(
    parameter int WINDOW      = sws_pkg::DEF_WINDOW,
    parameter int MAX_SEGMENT = sws_pkg::DEF_MAX_SEGMENT
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        q_valid,
    output logic                        q_pop,
    input  sws_pkg::cmd_t               q_cmd,
    input  logic [sws_pkg::LIMIT_W-1:0] window_limit,
    sws_out_if.source                   result
);
    import sws_pkg::*;

    localparam int PTR_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int CNT_W = $clog2(WINDOW + 1);
    localparam int SUM_W = CNT_W + 1;
    localparam int CMP_W = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;
    localparam int SEG_W = 17;

    typedef enum logic [5:0] {
        ST_IDLE      = 6'b000001,
        ST_EMIT      = 6'b000010,
        ST_RETX_RD   = 6'b000100,
        ST_RETX_EMIT = 6'b001000,
        ST_POP_RD    = 6'b010000,
        ST_POP_CMP   = 6'b100000
    } state_t;

    state_t             state_reg, state_next;
    cmd_t               cmd_reg, cmd_next;
    logic [PTR_W-1:0]   head_reg, head_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [CNT_W-1:0]   idx_reg, idx_next;
    logic [SEQ_W-1:0]   next_seq_reg, next_seq_next;
    logic               end_sent_reg, end_sent_next;
    logic               out_valid_reg, out_valid_next;
    result_t            out_reg, out_next;

    logic [SEQ_W-1:0]   mem_seq [WINDOW];
    logic [LEN_W-1:0]   mem_len [WINDOW];
    logic [SEQ_W-1:0]   rd_seq_reg;
    logic [LEN_W-1:0]   rd_len_reg;
    logic [PTR_W-1:0]   rd_addr, wr_slot;
    logic               mem_we;

    logic               out_free;
    logic [CMP_W-1:0]   lim_eff;
    logic               reject;
    logic [CNT_W-1:0]   idx_inc;
    logic               retx_last;

    // Slot at a given offset from the head, modulo the window depth.
    function automatic logic [PTR_W-1:0] wrap_slot(input logic [PTR_W-1:0] base,
                                                   input logic [CNT_W-1:0] off);
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(base) + SUM_W'(off);
        if (sum >= SUM_W'(WINDOW))
        begin
            sum = sum - SUM_W'(WINDOW);
        end
        return sum[PTR_W-1:0];
    endfunction

    assign out_free = !out_valid_reg || result.ready;
    assign wr_slot  = wrap_slot(head_reg, count_reg);
    assign rd_addr  = (state_reg == ST_RETX_RD || state_reg == ST_RETX_EMIT)
                      ? wrap_slot(head_reg, idx_reg) : head_reg;

    // Offer admission: clamped window limit, end marker and segment size.
    always_comb
    begin
        lim_eff = CMP_W'(window_limit);
        if (lim_eff == '0)
        begin
            lim_eff = CMP_W'(1);
        end
        if (lim_eff > CMP_W'(WINDOW))
        begin
            lim_eff = CMP_W'(WINDOW);
        end
        reject = end_sent_reg || (CMP_W'(count_reg) >= lim_eff)
                 || (SEG_W'(cmd_reg.len) > SEG_W'(MAX_SEGMENT));
    end

    assign idx_inc   = idx_reg + CNT_W'(1);
    assign retx_last = (idx_inc == count_reg);

    // Command sequencer.
    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        head_next      = head_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        next_seq_next  = next_seq_reg;
        end_sent_next  = end_sent_reg;
        out_valid_next = out_valid_reg && !result.ready;
        out_next       = out_reg;
        q_pop          = 1'b0;
        mem_we         = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop    = 1'b1;
                    cmd_next = q_cmd;
                    case (q_cmd.op)
                        CMD_RETX:
                        begin
                            if (count_reg == '0)
                            begin
                                cmd_next.op = CMD_STATUS;
                                state_next  = ST_EMIT;
                            end
                            else
                            begin
                                idx_next   = '0;
                                state_next = ST_RETX_RD;
                            end
                        end
                        CMD_NEW_ACK: state_next = ST_POP_RD;
                        default:     state_next = ST_EMIT;
                    endcase
                end
            end

            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_next.last  = 1'b1;
                    if (cmd_reg.op == CMD_OFFER)
                    begin
                        out_next.seq_number = next_seq_reg;
                        out_next.length     = cmd_reg.len;
                        if (reject)
                        begin
                            out_next.kind = KIND_REJECT;
                        end
                        else
                        begin
                            out_next.kind = KIND_SEND;
                            mem_we        = 1'b1;
                            count_next    = count_reg + CNT_W'(1);
                            next_seq_next = next_seq_reg + SEQ_W'(cmd_reg.len);
                            end_sent_next = end_sent_reg || (cmd_reg.len == '0);
                        end
                    end
                    else
                    begin
                        out_next.kind       = KIND_STATUS;
                        out_next.seq_number = cmd_reg.value;
                        out_next.length     = '0;
                    end
                    state_next = ST_IDLE;
                end
            end

            ST_RETX_RD:
            begin
                state_next = ST_RETX_EMIT;
            end

            ST_RETX_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next      = 1'b1;
                    out_next.kind       = KIND_RETX;
                    out_next.seq_number = rd_seq_reg;
                    out_next.length     = rd_len_reg;
                    out_next.last       = retx_last;
                    idx_next            = idx_inc;
                    state_next          = retx_last ? ST_IDLE : ST_RETX_RD;
                end
            end

            ST_POP_RD:
            begin
                if (count_reg == '0)
                begin
                    cmd_next.op = CMD_STATUS;
                    state_next  = ST_EMIT;
                end
                else
                begin
                    state_next = ST_POP_CMP;
                end
            end

            ST_POP_CMP:
            begin
                // Drop the head unless it matches the acknowledgement.
                if (rd_seq_reg != cmd_reg.value)
                begin
                    head_next  = (head_reg == PTR_W'(WINDOW - 1)) ? '0
                                 : head_reg + PTR_W'(1);
                    count_next = count_reg - CNT_W'(1);
                    state_next = ST_POP_RD;
                end
                else
                begin
                    cmd_next.op = CMD_STATUS;
                    state_next  = ST_EMIT;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Window status after this step goes with every result.
        out_next.outstanding = OUTST_W'(count_next);
        out_next.done_res    = end_sent_next && (count_next == '0);
        if (!(out_valid_next && !out_valid_reg) && !(out_valid_next && result.ready))
        begin
            out_next.outstanding = out_reg.outstanding;
            out_next.done_res    = out_reg.done_res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            head_reg      <= '0;
            count_reg     <= '0;
            idx_reg       <= '0;
            next_seq_reg  <= '0;
            end_sent_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            next_seq_reg  <= next_seq_next;
            end_sent_reg  <= end_sent_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        out_reg <= out_next;
    end

    // Window store with one write port and a registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem_seq[wr_slot] <= next_seq_reg;
            mem_len[wr_slot] <= cmd_reg.len;
        end
        rd_seq_reg <= mem_seq[rd_addr];
        rd_len_reg <= mem_len[rd_addr];
    end

    assign result.valid       = out_valid_reg;
    assign result.kind        = out_reg.kind;
    assign result.seq_number  = out_reg.seq_number;
    assign result.length      = out_reg.length;
    assign result.last        = out_reg.last;
    assign result.outstanding = out_reg.outstanding;
    assign result.done_res    = out_reg.done_res;

endmodule

// ----- sim/tb_sliding_window_sender.sv -----
// Self-checking testbench of the sliding window sender: a directed table, then random
// offers and acknowledgements over several register settings, checked by a predictor.
// Depends on sws_pkg, the channel interfaces and the sliding_window_sender top level.
`timescale 1ns / 1ps

module tb_sliding_window_sender;
    import sws_pkg::*;

    localparam int CLK_PERIOD    = 4;
    localparam int SETTLE_CYCLES = 64;
    localparam int LONG_HOLD     = 300;
    localparam int TIMEOUT_NS    = 2_000_000;
    localparam int MAX_REPORTS   = 10;

    // One row of the directed table; typed rows carry their single result.
    typedef struct {
        logic             op;
        logic [LEN_W-1:0] len;
        logic [SEQ_W-1:0] ack;
        bit               typed;
        result_t          res;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n;

    sws_in_if  item_ch ();
    sws_cfg_if cfg_ch ();
    sws_out_if res_ch ();

    sliding_window_sender u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .cfg    (cfg_ch),
        .result (res_ch)
    );

    // Shadow copy of the sender state and its two registers.
    logic [SEQ_W-1:0]   shadow_seq [DEF_WINDOW];
    logic [LEN_W-1:0]   shadow_len [DEF_WINDOW];
    int unsigned        shadow_head;
    int unsigned        shadow_count;
    logic [SEQ_W-1:0]   shadow_next_seq;
    logic [SEQ_W-1:0]   shadow_last_ack;
    logic [THR_W-1:0]   shadow_dups;
    bit                 shadow_end;
    logic [LIMIT_W-1:0] shadow_limit;
    logic [THR_W-1:0]   shadow_thr;

    // Results of the latest request, and all results still awaited from the block.
    result_t step_results [$];
    result_t pending_results [$];
    stim_row_t directed_rows [$];

    int unsigned tx_idle_pct;
    int unsigned rx_idle_pct;
    bit          long_hold_req;
    int unsigned failures;
    int unsigned requests_sent;
    int unsigned results_seen;
    int unsigned retx_seen;
    int unsigned reject_seen;
    int unsigned done_seen;
    int unsigned settings_used;

    always #(CLK_PERIOD / 2) clk = ~clk;

    function automatic result_t make_result(kind_t kind, logic [SEQ_W-1:0] seq,
                                            logic [LEN_W-1:0] len);
        result_t r;
        r.kind        = kind;
        r.seq_number  = seq;
        r.length      = len;
        r.last        = 1'b0;
        r.outstanding = OUTST_W'(shadow_count);
        r.done_res    = shadow_end && (shadow_count == 0);
        return r;
    endfunction

    // Work out the results of one request and advance the shadow state.
    function automatic void predict_sender_results(logic op, logic [LEN_W-1:0] len,
                                                   logic [SEQ_W-1:0] ack);
        int unsigned lim;
        int unsigned thr;
        int unsigned slot;
        result_t     r;
        step_results.delete();
        if (op == OPC_OFFER) begin
            lim = shadow_limit;
            if (lim == 0)
                lim = 1;
            if (lim > DEF_WINDOW)
                lim = DEF_WINDOW;
            if (shadow_end || shadow_count >= lim || len > DEF_MAX_SEGMENT) begin
                step_results.push_back(make_result(KIND_REJECT, shadow_next_seq, len));
            end
            else begin
                slot = (shadow_head + shadow_count) % DEF_WINDOW;
                shadow_seq[slot] = shadow_next_seq;
                shadow_len[slot] = len;
                shadow_count++;
                shadow_next_seq = shadow_next_seq + SEQ_W'(len);
                if (len == 0)
                    shadow_end = 1'b1;
                step_results.push_back(make_result(KIND_SEND, shadow_seq[slot], len));
            end
        end
        else if (ack <= shadow_last_ack) begin
            // Duplicate: count it, and resend the whole window at the threshold.
            thr = (shadow_thr == 0) ? 1 : shadow_thr;
            shadow_dups = shadow_dups + 1'b1;
            if (shadow_dups >= thr) begin
                shadow_dups = '0;
                for (int unsigned i = 0; i < shadow_count; i++) begin
                    slot = (shadow_head + i) % DEF_WINDOW;
                    step_results.push_back(make_result(KIND_RETX, shadow_seq[slot],
                                                       shadow_len[slot]));
                end
            end
            if (step_results.size() == 0)
                step_results.push_back(make_result(KIND_STATUS, shadow_last_ack, '0));
        end
        else begin
            // New acknowledgement: pop from the head until the head matches.
            shadow_last_ack = ack;
            shadow_dups     = '0;
            while (shadow_count > 0 && shadow_seq[shadow_head] != ack) begin
                shadow_head = (shadow_head + 1) % DEF_WINDOW;
                shadow_count--;
            end
            step_results.push_back(make_result(KIND_STATUS, shadow_last_ack, '0));
        end
        r = step_results.pop_back();
        r.last = 1'b1;
        step_results.push_back(r);
    endfunction

    function automatic void add_row(logic op, logic [LEN_W-1:0] len, logic [SEQ_W-1:0] ack,
                                    bit typed, kind_t kind, logic [SEQ_W-1:0] seq,
                                    logic [LEN_W-1:0] rlen, int unsigned outst, bit done);
        stim_row_t row;
        row.op              = op;
        row.len             = len;
        row.ack             = ack;
        row.typed           = typed;
        row.res.kind        = kind;
        row.res.seq_number  = seq;
        row.res.length      = rlen;
        row.res.last        = 1'b1;
        row.res.outstanding = OUTST_W'(outst);
        row.res.done_res    = done;
        directed_rows.push_back(row);
    endfunction

    // Offer lengths: mostly legal, some oversized, end of file only when allowed.
    function automatic logic [LEN_W-1:0] pick_length(bit eof_ok);
        int unsigned r;
        r = $urandom_range(99);
        if (r < 6)
            return LEN_W'($urandom_range(2047, DEF_MAX_SEGMENT + 1));
        if (r < 10)
            return LEN_W'(DEF_MAX_SEGMENT);
        if (eof_ok && r < 30)
            return '0;
        return LEN_W'($urandom_range(DEF_MAX_SEGMENT, 1));
    endfunction

    // Acknowledgement numbers aimed at the window: duplicates, entry matches and
    // numbers past the window, with wild values only late in the run.
    function automatic logic [SEQ_W-1:0] pick_ack(bit wild_ok);
        int unsigned r;
        int unsigned idx;
        r = $urandom_range(99);
        if (r < 30) begin
            if ($urandom_range(1) == 0)
                return shadow_last_ack;
            return $urandom_range(shadow_last_ack, 0);
        end
        if (r < 70 && shadow_count > 0) begin
            idx = $urandom_range(shadow_count - 1, 0);
            return shadow_seq[(shadow_head + idx) % DEF_WINDOW];
        end
        if (r < 85)
            return shadow_next_seq;
        if (wild_ok && r < 95) begin
            if ($urandom_range(3) == 0)
                return '1;
            return $urandom();
        end
        return shadow_next_seq + $urandom_range(2000, 1);
    endfunction

    // Offer one request, wait for it to be taken, then log what it should cause.
    task automatic send_request(logic op, logic [LEN_W-1:0] len, logic [SEQ_W-1:0] ack,
                                bit typed, result_t typed_res);
        item_ch.valid          <= 1'b1;
        item_ch.opcode         <= op;
        item_ch.segment_length <= len;
        item_ch.ack_number     <= ack;
        @(posedge clk);
        while (!item_ch.ready)
            @(posedge clk);
        requests_sent++;
        predict_sender_results(op, len, ack);
        if (typed)
            pending_results.push_back(typed_res);
        else
            foreach (step_results[i])
                pending_results.push_back(step_results[i]);
        if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
            item_ch.valid <= 1'b0;
            repeat ($urandom_range(16, 1))
                @(posedge clk);
        end
    endtask

    // Stop offering and let the block drain completely.
    task automatic drain_block();
        item_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    task automatic write_settings(logic [LIMIT_W-1:0] lim, logic [THR_W-1:0] thr);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= REG_WINDOW_LIMIT;
        cfg_ch.data  <= CFG_DAT_W'(lim);
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        shadow_limit = lim;
        cfg_ch.index <= REG_DUP_THRESHOLD;
        cfg_ch.data  <= CFG_DAT_W'(thr);
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        shadow_thr = thr;
        cfg_ch.valid <= 1'b0;
        settings_used++;
        @(posedge clk);
    endtask

    task automatic run_random_phase(int n_items, int unsigned offer_pct, int eof_from,
                                    int wild_from, int hold_at, int pause_at);
        logic             op;
        logic [LEN_W-1:0] len;
        logic [SEQ_W-1:0] ack;
        result_t          no_res;
        no_res = '0;
        for (int k = 0; k < n_items; k++) begin
            if (k == hold_at)
                long_hold_req = 1'b1;
            // Sender pause: wait for every awaited result before going on.
            if (k == pause_at) begin
                item_ch.valid <= 1'b0;
                @(posedge clk);
                while (pending_results.size() != 0)
                    @(posedge clk);
            end
            op = ($urandom_range(99) < offer_pct) ? OPC_OFFER : OPC_ACK;
            if (op == OPC_OFFER) begin
                len = pick_length(k >= eof_from);
                ack = $urandom();
            end
            else begin
                len = LEN_W'($urandom());
                ack = pick_ack(k >= wild_from);
            end
            send_request(op, len, ack, 1'b0, no_res);
        end
    endtask

    function automatic void note_failure(string what, result_t got, result_t want);
        failures++;
        if (failures <= MAX_REPORTS) begin
            $display("%s: got kind %0d seq %h len %0d last %b out %0d done %b,",
                     what, got.kind, got.seq_number, got.length, got.last,
                     got.outstanding, got.done_res);
            $display("    expected kind %0d seq %h len %0d last %b out %0d done %b",
                     want.kind, want.seq_number, want.length, want.last,
                     want.outstanding, want.done_res);
        end
    endfunction

    // Compare each accepted result with the oldest awaited one.
    always @(posedge clk) begin : check_results
        result_t got;
        result_t want;
        if (rst_n && res_ch.valid && res_ch.ready) begin
            got.kind        = kind_t'(res_ch.kind);
            got.seq_number  = res_ch.seq_number;
            got.length      = res_ch.length;
            got.last        = res_ch.last;
            got.outstanding = res_ch.outstanding;
            got.done_res    = res_ch.done_res;
            results_seen++;
            if (got.kind == KIND_RETX)
                retx_seen++;
            if (got.kind == KIND_REJECT)
                reject_seen++;
            if (got.done_res === 1'b1)
                done_seen++;
            if (pending_results.size() == 0) begin
                note_failure("unexpected result", got, '0);
            end
            else begin
                want = pending_results.pop_front();
                if (got !== want)
                    note_failure("result mismatch", got, want);
            end
        end
    end

    // Result receiver: random stalls, and one long hold-off when asked.
    initial begin : result_receiver
        res_ch.ready <= 1'b0;
        @(posedge clk);
        while (rst_n !== 1'b1)
            @(posedge clk);
        forever begin
            @(posedge clk);
            if (long_hold_req) begin
                res_ch.ready <= 1'b0;
                repeat (LONG_HOLD)
                    @(posedge clk);
                long_hold_req = 1'b0;
                res_ch.ready <= 1'b1;
            end
            else if (rx_idle_pct != 0 && $urandom_range(99) < rx_idle_pct) begin
                res_ch.ready <= 1'b0;
                repeat ($urandom_range(16, 1))
                    @(posedge clk);
                res_ch.ready <= 1'b1;
            end
            else begin
                res_ch.ready <= 1'b1;
            end
        end
    end

    initial begin : watchdog
        #(TIMEOUT_NS);
        $display("tb_sliding_window_sender failed");
        $finish;
    end

    // Main sequence: reset, directed table, then random phases per setting.
    initial begin : stimulus
        failures      = 0;
        requests_sent = 0;
        results_seen  = 0;
        retx_seen     = 0;
        reject_seen   = 0;
        done_seen     = 0;
        settings_used = 1;
        long_hold_req = 1'b0;
        tx_idle_pct   = 20;
        rx_idle_pct   = 20;

        item_ch.valid          <= 1'b0;
        item_ch.opcode         <= OPC_OFFER;
        item_ch.segment_length <= '0;
        item_ch.ack_number     <= '0;
        cfg_ch.valid           <= 1'b0;
        cfg_ch.index           <= REG_WINDOW_LIMIT;
        cfg_ch.data            <= '0;
        rst_n = 1'b0;

        shadow_head     = 0;
        shadow_count    = 0;
        shadow_next_seq = '0;
        shadow_last_ack = '0;
        shadow_dups     = '0;
        shadow_end      = 1'b0;
        shadow_limit    = LIMIT_RESET;
        shadow_thr      = THR_RESET;

        repeat (12)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Duplicates on an empty window, including the threshold.
        add_row(OPC_ACK,   11'd0,    32'd0, 1, KIND_STATUS, 32'd0, 11'd0, 0, 0);
        add_row(OPC_ACK,   11'd2047, 32'd0, 1, KIND_STATUS, 32'd0, 11'd0, 0, 0);
        add_row(OPC_ACK,   11'd0,    32'd0, 1, KIND_STATUS, 32'd0, 11'd0, 0, 0);
        // Largest segment, oversized offers, then a one-byte segment.
        add_row(OPC_OFFER, 11'd1024, '1,    1, KIND_SEND,   32'd0,    11'd1024, 1, 0);
        add_row(OPC_OFFER, 11'd1025, 32'd0, 1, KIND_REJECT, 32'd1024, 11'd1025, 1, 0);
        add_row(OPC_OFFER, 11'd2047, 32'd0, 1, KIND_REJECT, 32'd1024, 11'd2047, 1, 0);
        add_row(OPC_OFFER, 11'd1,    32'd0, 1, KIND_SEND,   32'd1024, 11'd1,    2, 0);
        add_row(OPC_OFFER, 11'd500,  32'd0, 0, KIND_SEND,   32'd0, 11'd0, 0, 0);
        add_row(OPC_OFFER, 11'd7,    32'd0, 0, KIND_SEND,   32'd0, 11'd0, 0, 0);
        // Three duplicates resend the whole window.
        add_row(OPC_ACK,   11'd0,    32'd0, 0, KIND_STATUS, 32'd0, 11'd0, 0, 0);
        add_row(OPC_ACK,   11'd0,    32'd0, 0, KIND_STATUS, 32'd0, 11'd0, 0, 0);
        add_row(OPC_ACK,   11'd0,    32'd0, 0, KIND_STATUS, 32'd0, 11'd0, 0, 0);
        // New acknowledgements, one below and one equal to the last.
        add_row(OPC_ACK,   11'd0,    32'd1024, 0, KIND_STATUS, 32'd0, 11'd0, 0, 0);
        add_row(OPC_ACK,   11'd0,    32'd1000, 0, KIND_STATUS, 32'd0, 11'd0, 0, 0);
        add_row(OPC_ACK,   11'd0,    32'd1025, 0, KIND_STATUS, 32'd0, 11'd0, 0, 0);
        add_row(OPC_ACK,   11'd0,    32'd1025, 0, KIND_STATUS, 32'd0, 11'd0, 0, 0);
        // An acknowledgement that matches no entry empties the window.
        add_row(OPC_ACK,   11'd0,    32'd1532, 0, KIND_STATUS, 32'd0, 11'd0, 0, 0);
        add_row(OPC_OFFER, 11'd1,    32'd0,    0, KIND_SEND,   32'd0, 11'd0, 0, 0);
        add_row(OPC_ACK,   11'd0,    32'd1532, 0, KIND_STATUS, 32'd0, 11'd0, 0, 0);

        foreach (directed_rows[i])
            send_request(directed_rows[i].op, directed_rows[i].len, directed_rows[i].ack,
                         directed_rows[i].typed, directed_rows[i].res);
        drain_block();

        // Widest window with a single duplicate as threshold.
        tx_idle_pct = 25;
        rx_idle_pct = 25;
        write_settings(5'd16, 4'd1);
        run_random_phase(60, 55, 1000, 1000, -1, -1);
        drain_block();

        // One segment in flight and the highest threshold, with no idling.
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        write_settings(5'd1, 4'd15);
        run_random_phase(50, 50, 1000, 1000, -1, -1);
        drain_block();

        // Zero values act as the smallest legal ones.
        tx_idle_pct = 30;
        rx_idle_pct = 10;
        write_settings(5'd0, 4'd0);
        run_random_phase(40, 50, 1000, 1000, -1, -1);
        drain_block();

        // Limit above the store size; the receiver holds off for a long stretch.
        tx_idle_pct = 10;
        rx_idle_pct = 30;
        write_settings(5'd31, 4'd2);
        run_random_phase(70, 75, 1000, 1000, 10, -1);
        drain_block();

        // Limit just past the store size; the sender pauses mid-phase.
        tx_idle_pct = 20;
        rx_idle_pct = 20;
        write_settings(5'd17, 4'd4);
        run_random_phase(60, 60, 1000, 1000, -1, 30);
        drain_block();

        // Last part at full rate: end of file, its release and wild numbers.
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        write_settings(5'd5, 4'd3);
        run_random_phase(70, 55, 15, 50, -1, -1);
        drain_block();

        $display("Covered %0d requests and %0d results under %0d register settings,",
                 requests_sent, results_seen, settings_used);
        $display("with %0d retransmits, %0d rejected offers and %0d done results.",
                 retx_seen, reject_seen, done_seen);
        if (failures == 0 && pending_results.size() == 0)
            $display("tb_sliding_window_sender passed");
        else
            $display("tb_sliding_window_sender failed");
        $finish;
    end

endmodule

// ----- sliding_window_sender.f -----
src/sws_pkg.sv
src/sws_ifs.sv
src/sws_front.sv
src/sws_queue.sv
src/sws_back.sv
src/sliding_window_sender.sv
sim/tb_sliding_window_sender.sv
